// ----- hdl/tssd_pkg.sv -----
// ----------------------------------------------------------------------------
// tssd_pkg
// shared widths, request and response types for the triangle side unit
// ----------------------------------------------------------------------------
package tssd_pkg;

   // coordinate and fixed point set-up
   localparam int COORD_BITS = 16;
   localparam int FRAC_BITS  = 8;

   // fixed field widths of the request and response
   localparam int FIELD_BITS = 16;
   localparam int SIDE_BITS  = 25;

   // derived arithmetic widths
   localparam int SQ_BITS   = 2 * COORD_BITS;
   localparam int SUM_BITS  = SQ_BITS + 2;
   localparam int RAD_BITS  = SUM_BITS + 2 * FRAC_BITS;
   localparam int ROOT_BITS = RAD_BITS / 2;
   localparam int REM_BITS  = ROOT_BITS + 2;

   // root digits resolved per pipeline stage
   localparam int ROOT_STEPS  = 2;
   localparam int ROOT_STAGES = (ROOT_BITS + ROOT_STEPS - 1) / ROOT_STEPS;

   typedef enum logic [1:0] {
      PAIR_12 = 2'd0,
      PAIR_23 = 2'd1,
      PAIR_31 = 2'd2
   } pair_type;

   typedef struct packed {
      logic signed [FIELD_BITS-1:0] p1_x;
      logic signed [FIELD_BITS-1:0] p1_y;
      logic signed [FIELD_BITS-1:0] p1_z;
      logic signed [FIELD_BITS-1:0] p2_x;
      logic signed [FIELD_BITS-1:0] p2_y;
      logic signed [FIELD_BITS-1:0] p2_z;
      logic signed [FIELD_BITS-1:0] p3_x;
      logic signed [FIELD_BITS-1:0] p3_y;
      logic signed [FIELD_BITS-1:0] p3_z;
   } req_type;

   typedef struct packed {
      logic [SIDE_BITS-1:0] side_12;
      logic [SIDE_BITS-1:0] side_23;
      logic [SIDE_BITS-1:0] side_31;
      logic [SIDE_BITS-1:0] shortest_side;
      pair_type             shortest_pair;
   } rsp_type;

endpackage

// ----- hdl/triangle_shortest_side_3d.sv -----
// ----------------------------------------------------------------------------
// triangle_shortest_side_3d
// side lengths of a 3d triangle and the shortest of them
// ----------------------------------------------------------------------------
// usage
//   a request carries the three vertices (req_data, 16 bit two's complement
//   coordinates) on a valid/ready channel; each request gives one response
//   on rsp_valid/rsp_ready with the three side lengths, the shortest one and
//   which pair of vertices it joins (ties go to side 1-2, then 2-3)
//   lengths are unsigned fixed point with FRAC_BITS fraction bits, truncated
//   throughput: one request per cycle while the skid register is empty, no state between requests
//   pipeline: 3 stages of difference, square and sum, 13 root stages of up
//   to 2 bits each, a compare stage and the output register; the root
//   pipeline sets the depth
//   stall: the whole pipeline holds while the skid register is full; a
//   response that cannot leave parks there, so req_ready is low while it
//   is parked and nothing is lost or repeated
//   reset: synchronous, clears every valid bit, the pipeline empties at once
//   and req_ready is high in the cycle after reset
// ----------------------------------------------------------------------------
module triangle_shortest_side_3d
   import tssd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   // sign extend a field to the working coordinate width
   function automatic logic signed [COORD_BITS-1:0] sext_coord(
      logic signed [FIELD_BITS-1:0] f);
      logic [COORD_BITS+FIELD_BITS-1:0] w;
      w = {{COORD_BITS{f[FIELD_BITS-1]}}, f};
      return w[COORD_BITS-1:0];
   endfunction

   // fit a root to the side field width
   function automatic logic [SIDE_BITS-1:0] fit_side(logic [ROOT_BITS-1:0] r);
      logic [ROOT_BITS+SIDE_BITS-1:0] w;
      w = {{SIDE_BITS{1'b0}}, r};
      return w[SIDE_BITS-1:0];
   endfunction

   // pipeline advances whenever the skid register is empty
   logic en;

   logic signed [COORD_BITS-1:0] pt [3][3];

   logic                  v_diff_ff;
   logic [COORD_BITS-1:0] diff_in [3][3];
   logic [COORD_BITS-1:0] diff_ff [3][3];

   logic               v_sq_ff;
   logic [SQ_BITS-1:0] sq_in [3][3];
   logic [SQ_BITS-1:0] sq_ff [3][3];

   logic                v_sum_ff;
   logic [SUM_BITS-1:0] sum_in [3];
   logic [SUM_BITS-1:0] sum_ff [3];

   logic [ROOT_STAGES-1:0] v_root_ff;
   logic [ROOT_BITS-1:0]   root_out [3];

   logic    v_cmp_ff;
   rsp_type cmp_in;
   rsp_type cmp_ff;

   logic    out_valid_ff;
   rsp_type out_ff;
   logic    skid_valid_ff;
   rsp_type skid_ff;
   logic    out_take;

   assign en        = !skid_valid_ff;
   assign req_ready = en;

   // vertices, point index then axis
   assign pt[0][0] = sext_coord(req_data.p1_x);
   assign pt[0][1] = sext_coord(req_data.p1_y);
   assign pt[0][2] = sext_coord(req_data.p1_z);
   assign pt[1][0] = sext_coord(req_data.p2_x);
   assign pt[1][1] = sext_coord(req_data.p2_y);
   assign pt[1][2] = sext_coord(req_data.p2_z);
   assign pt[2][0] = sext_coord(req_data.p3_x);
   assign pt[2][1] = sext_coord(req_data.p3_y);
   assign pt[2][2] = sext_coord(req_data.p3_z);

   // stage 1: absolute coordinate differences, side i runs vertex i to i+1, modulo 3
   always_comb begin
      logic signed [COORD_BITS:0] dwide;
      logic [COORD_BITS:0]        mag;
      int                         nb;
      for (int i = 0; i < 3; i++) begin
         nb = (i == 2) ? 0 : i + 1;
         for (int k = 0; k < 3; k++) begin
            dwide = {pt[nb][k][COORD_BITS-1], pt[nb][k]}
                  - {pt[i][k][COORD_BITS-1], pt[i][k]};
            mag   = dwide[COORD_BITS] ? (~dwide + 1'b1) : dwide;
            diff_in[i][k] = mag[COORD_BITS-1:0];
         end
      end
   end

   // stage 2: squares
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         for (int k = 0; k < 3; k++) begin
            sq_in[i][k] = diff_ff[i][k] * diff_ff[i][k];
         end
      end
   end

   // stage 3: sum of squares per side
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         sum_in[i] = SUM_BITS'(sq_ff[i][0]) + SUM_BITS'(sq_ff[i][1])
                   + SUM_BITS'(sq_ff[i][2]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         diff_ff <= diff_in;
         sq_ff   <= sq_in;
         sum_ff  <= sum_in;
      end
   end

   // root pipelines, one per side
   for (genvar i = 0; i < 3; i++) begin : g_side
      tssd_root u_root (
         .clock (clock),
         .en    (en),
         .sum   (sum_ff[i]),
         .root  (root_out[i])
      );
   end

   // compare stage, ties go to the earlier side
   always_comb begin
      cmp_in.side_12 = fit_side(root_out[0]);
      cmp_in.side_23 = fit_side(root_out[1]);
      cmp_in.side_31 = fit_side(root_out[2]);
      if (cmp_in.side_12 <= cmp_in.side_23 && cmp_in.side_12 <= cmp_in.side_31) begin
         cmp_in.shortest_pair = PAIR_12;
         cmp_in.shortest_side = cmp_in.side_12;
      end else if (cmp_in.side_23 <= cmp_in.side_12 &&
                   cmp_in.side_23 <= cmp_in.side_31) begin
         cmp_in.shortest_pair = PAIR_23;
         cmp_in.shortest_side = cmp_in.side_23;
      end else begin
         cmp_in.shortest_pair = PAIR_31;
         cmp_in.shortest_side = cmp_in.side_31;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cmp_ff <= cmp_in;
      end
   end

   // valid bits travel beside the data
   always_ff @(posedge clock) begin
      if (reset) begin
         v_diff_ff <= 1'b0;
         v_sq_ff   <= 1'b0;
         v_sum_ff  <= 1'b0;
         v_root_ff <= '0;
         v_cmp_ff  <= 1'b0;
      end else if (en) begin
         v_diff_ff <= req_valid;
         v_sq_ff   <= v_diff_ff;
         v_sum_ff  <= v_sq_ff;
         v_root_ff <= {v_root_ff[ROOT_STAGES-2:0], v_sum_ff};
         v_cmp_ff  <= v_root_ff[ROOT_STAGES-1];
      end
   end

   // output register with a skid register behind it
   assign out_take = !out_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         // pipeline is frozen, drain the parked response first
         if (rsp_ready) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end
      end else if (v_cmp_ff) begin
         if (out_take) begin
            out_valid_ff <= 1'b1;
         end else begin
            skid_valid_ff <= 1'b1;
         end
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (rsp_ready) begin
            out_ff <= skid_ff;
         end
      end else if (v_cmp_ff) begin
         if (out_take) begin
            out_ff <= cmp_ff;
         end else begin
            skid_ff <= cmp_ff;
         end
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

endmodule

// ----- hdl/tssd_root.sv -----
// ----------------------------------------------------------------------------
// tssd_root
// pipelined fixed point square root, up to two result bits per stage
// ----------------------------------------------------------------------------
module tssd_root
   import tssd_pkg::*;
(
   input  logic                 clock,
   input  logic                 en,
   input  logic [SUM_BITS-1:0]  sum,
   output logic [ROOT_BITS-1:0] root
);

   typedef struct packed {
      logic [RAD_BITS-1:0]  rad;
      logic [REM_BITS-1:0]  rem;
      logic [ROOT_BITS-1:0] root;
   } root_state_type;

   // one restoring step: bring down two radicand bits, try 4r+1
   function automatic root_state_type root_step(root_state_type st);
      root_state_type      nx;
      logic [REM_BITS-1:0] part;
      logic [REM_BITS-1:0] trial;
      part   = {st.rem[REM_BITS-3:0], st.rad[RAD_BITS-1 -: 2]};
      trial  = {st.root, 2'b01};
      nx.rad = {st.rad[RAD_BITS-3:0], 2'b00};
      if (part >= trial) begin
         nx.rem  = part - trial;
         nx.root = {st.root[ROOT_BITS-2:0], 1'b1};
      end else begin
         nx.rem  = part;
         nx.root = {st.root[ROOT_BITS-2:0], 1'b0};
      end
      return nx;
   endfunction

   // steps of one stage, the last stage may run short
   function automatic root_state_type root_stage(root_state_type st, int first);
      root_state_type cur;
      cur = st;
      for (int j = 0; j < ROOT_STEPS; j++) begin
         if (first + j < ROOT_BITS) begin
            cur = root_step(cur);
         end
      end
      return cur;
   endfunction

   root_state_type start;
   root_state_type stage_prev [ROOT_STAGES];
   root_state_type stage_in   [ROOT_STAGES];
   root_state_type stage_ff   [ROOT_STAGES];

   always_comb begin
      start.rad  = RAD_BITS'(sum) << (2 * FRAC_BITS);
      start.rem  = '0;
      start.root = '0;
   end

   for (genvar s = 0; s < ROOT_STAGES; s++) begin : g_stage
      if (s == 0) begin : g_first
         assign stage_prev[s] = start;
      end else begin : g_next
         assign stage_prev[s] = stage_ff[s-1];
      end
      assign stage_in[s] = root_stage(stage_prev[s], s * ROOT_STEPS);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         stage_ff <= stage_in;
      end
   end

   assign root = stage_ff[ROOT_STAGES-1].root;

endmodule

// ----- hdl/tssd_checker.sv -----
// ----------------------------------------------------------------------------
// tssd_checker
// port level checks on the triangle side unit, bound to the top level
// ----------------------------------------------------------------------------
module tssd_checker
   import tssd_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed or dropped");

   // no response straight after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // reported shortest matches the side named by the pair code
   a_pair_match: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         (rsp_data.shortest_pair == PAIR_12 &&
          rsp_data.shortest_side == rsp_data.side_12) ||
         (rsp_data.shortest_pair == PAIR_23 &&
          rsp_data.shortest_side == rsp_data.side_23) ||
         (rsp_data.shortest_pair == PAIR_31 &&
          rsp_data.shortest_side == rsp_data.side_31))
      else $error("shortest pair does not match shortest side");

   // shortest is no longer than any side
   a_is_min: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         rsp_data.shortest_side <= rsp_data.side_12 &&
         rsp_data.shortest_side <= rsp_data.side_23 &&
         rsp_data.shortest_side <= rsp_data.side_31)
      else $error("shortest side is not the minimum");

   // ties never go to the last side, 3-1
   a_tie_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.shortest_pair == PAIR_31 |->
         rsp_data.side_12 > rsp_data.shortest_side &&
         rsp_data.side_23 > rsp_data.shortest_side)
      else $error("tie not resolved to the earlier side");

endmodule

bind triangle_shortest_side_3d tssd_checker u_tssd_checker (.*);

// ----- test/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for triangle_shortest_side_3d: streams triangles in over
// the request channel, predicts the three fixed point side lengths, the
// shortest side and its pair, and checks every response in order while both
// channels idle and stall at random
// ----------------------------------------------------------------------------
module testbench
   import tssd_pkg::*;
;

   timeunit 1ns;
   timeprecision 1ps;

   // cycles with no handshake on either channel before the run is abandoned
   localparam int QUIET_LIMIT  = 3000;
   // settle time after the last response, longer than the pipeline depth
   localparam int DRAIN_CYCLES = 40;
   // random triangles per idling phase
   localparam int PHASE_ITEMS  = 284;
   // cap on printed mismatch lines, the count goes on regardless
   localparam int PRINT_LIMIT  = 60;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   // triangles waiting to be driven, and the responses still owed by the block
   req_type triangle_queue[$];
   rsp_type expected_sides[$];

   // idling odds in percent, changed only on the falling edge
   int unsigned send_idle_pct  = 0;
   int unsigned recv_stall_pct = 0;

   int error_count    = 0;
   int response_count = 0;
   int quiet_cycles   = 0;

   triangle_shortest_side_3d uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // prediction
   // ---------------------------------------------------------------------

   // coordinate as seen by the block: only the low COORD_BITS count, signed
   function automatic longint coord_value(input logic [FIELD_BITS-1:0] raw);
      longint v;
      v = longint'(raw[COORD_BITS-1:0]);
      if (raw[COORD_BITS-1]) begin
         v = v - (longint'(1) << COORD_BITS);
      end
      return v;
   endfunction

   // floor(sqrt(squared distance * 2^(2*FRAC_BITS))), two radicand bits a step
   function automatic logic [SIDE_BITS-1:0] fixed_length(
      input longint ax, input longint ay, input longint az,
      input longint bx, input longint by, input longint bz);
      longint      dist_sq;
      logic [63:0] radicand;
      logic [63:0] root;
      logic [63:0] rem;
      logic [63:0] trial;
      dist_sq  = (bx - ax) * (bx - ax) + (by - ay) * (by - ay) + (bz - az) * (bz - az);
      radicand = 64'(dist_sq) << (2 * FRAC_BITS);
      root     = '0;
      rem      = '0;
      for (int p = 31; p >= 0; p--) begin
         rem   = (rem << 2) | ((radicand >> (2 * p)) & 64'd3);
         trial = (root << 2) | 64'd1;
         if (rem >= trial) begin
            rem  = rem - trial;
            root = (root << 1) | 64'd1;
         end else begin
            root = root << 1;
         end
      end
      return root[SIDE_BITS-1:0];
   endfunction

   // full response for one triangle; ties go to the earlier side
   function automatic rsp_type triangle_sides(input req_type t);
      longint  c [9];
      rsp_type r;
      c[0] = coord_value(t.p1_x);
      c[1] = coord_value(t.p1_y);
      c[2] = coord_value(t.p1_z);
      c[3] = coord_value(t.p2_x);
      c[4] = coord_value(t.p2_y);
      c[5] = coord_value(t.p2_z);
      c[6] = coord_value(t.p3_x);
      c[7] = coord_value(t.p3_y);
      c[8] = coord_value(t.p3_z);
      r.side_12 = fixed_length(c[0], c[1], c[2], c[3], c[4], c[5]);
      r.side_23 = fixed_length(c[3], c[4], c[5], c[6], c[7], c[8]);
      r.side_31 = fixed_length(c[6], c[7], c[8], c[0], c[1], c[2]);
      if (r.side_12 <= r.side_23 && r.side_12 <= r.side_31) begin
         r.shortest_side = r.side_12;
         r.shortest_pair = PAIR_12;
      end else if (r.side_23 <= r.side_12 && r.side_23 <= r.side_31) begin
         r.shortest_side = r.side_23;
         r.shortest_pair = PAIR_23;
      end else begin
         r.shortest_side = r.side_31;
         r.shortest_pair = PAIR_31;
      end
      return r;
   endfunction

   // packs nine coordinates into a request, each truncated to the field width
   function automatic req_type vertices(
      input int x1, input int y1, input int z1,
      input int x2, input int y2, input int z2,
      input int x3, input int y3, input int z3);
      req_type t;
      t.p1_x = x1[FIELD_BITS-1:0];
      t.p1_y = y1[FIELD_BITS-1:0];
      t.p1_z = z1[FIELD_BITS-1:0];
      t.p2_x = x2[FIELD_BITS-1:0];
      t.p2_y = y2[FIELD_BITS-1:0];
      t.p2_z = z2[FIELD_BITS-1:0];
      t.p3_x = x3[FIELD_BITS-1:0];
      t.p3_y = y3[FIELD_BITS-1:0];
      t.p3_z = z3[FIELD_BITS-1:0];
      return t;
   endfunction

   // ---------------------------------------------------------------------
   // checking
   // ---------------------------------------------------------------------

   task automatic report_mismatch(input string msg);
      if (error_count < PRINT_LIMIT) begin
         $display("%0t mismatch: %s", $realtime, msg);
      end
      error_count++;
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want) begin
         report_mismatch($sformatf("response %0d %s got %0d expected %0d",
                                   response_count, name, got, want));
      end
   endtask

   // ---------------------------------------------------------------------
   // request driver: one update per edge, valid held until accepted
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : drive_requests
      req_type next_tri;
      logic    next_valid;
      if (reset) begin
         req_valid <= 1'b0;
         req_data  <= '0;
      end else begin
         next_valid = req_valid;
         next_tri   = req_data;
         if (req_valid && req_ready) begin
            // request taken: its response joins the back of the line
            expected_sides.push_back(triangle_sides(req_data));
            next_valid = 1'b0;
         end
         if (!next_valid && triangle_queue.size() > 0 &&
             $urandom_range(99) >= send_idle_pct) begin
            next_tri   = triangle_queue.pop_front();
            next_valid = 1'b1;
         end
         req_valid <= next_valid;
         req_data  <= next_tri;
      end
   end

   // ---------------------------------------------------------------------
   // response monitor and receiver back-pressure
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : check_responses
      rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_sides.size() == 0) begin
               report_mismatch($sformatf("response %0d with no request outstanding",
                                         response_count));
            end else begin
               want = expected_sides.pop_front();
               check_field("side_12", 32'(rsp_data.side_12), 32'(want.side_12));
               check_field("side_23", 32'(rsp_data.side_23), 32'(want.side_23));
               check_field("side_31", 32'(rsp_data.side_31), 32'(want.side_31));
               check_field("shortest_side", 32'(rsp_data.shortest_side),
                           32'(want.shortest_side));
               check_field("shortest_pair", 32'(rsp_data.shortest_pair),
                           32'(want.shortest_pair));
            end
            response_count++;
         end
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // ---------------------------------------------------------------------
   // watchdog: gives up when neither channel moves for too long
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("[triangle_shortest_side_3d] ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ---------------------------------------------------------------------
   // stimulus and end of run
   // ---------------------------------------------------------------------
   initial begin : stimulus
      int pt     [9];
      int offs   [3];
      int corner [5];
      int kind;
      int a;
      int b;
      corner = '{-32768, -1, 0, 1, 32767};

      // directed triangles, sent back to back
      // all three vertices coincident
      triangle_queue.push_back(vertices(0, 0, 0, 0, 0, 0, 0, 0, 0));
      // two vertices coincident
      triangle_queue.push_back(vertices(0, 0, 0, 0, 0, 0, 5, 5, 5));
      // longest possible side along the cube diagonal
      triangle_queue.push_back(vertices(-32768, -32768, -32768, 32767, 32767, 32767,
                                        0, 0, 0));
      triangle_queue.push_back(vertices(32767, 32767, 32767, -32768, -32768, -32768,
                                        32767, 32767, 32767));
      triangle_queue.push_back(vertices(-32768, 32767, -32768, 32767, -32768, 32767,
                                        -32768, -32768, -32768));
      triangle_queue.push_back(vertices(0, -32768, 0, 0, 32767, 0, 0, 0, 32767));
      triangle_queue.push_back(vertices(0, 0, -32768, 0, 0, 32767, -32768, 0, 0));
      // three-way tie, equilateral
      triangle_queue.push_back(vertices(1, 0, 0, 0, 1, 0, 0, 0, 1));
      // two-way ties: 2-3 with 3-1, 1-2 with 3-1, 1-2 with 2-3
      triangle_queue.push_back(vertices(-10, 0, 0, 10, 0, 0, 0, 1, 0));
      triangle_queue.push_back(vertices(0, 1, 0, -10, 0, 0, 10, 0, 0));
      triangle_queue.push_back(vertices(-10, 0, 0, 0, 1, 0, 10, 0, 0));
      // strict shortest on each side in turn
      triangle_queue.push_back(vertices(0, 0, 0, 1, 0, 0, 100, 0, 0));
      triangle_queue.push_back(vertices(0, 0, 0, 100, 0, 0, 101, 0, 0));
      triangle_queue.push_back(vertices(0, 0, 0, 50, 0, 0, 0, 0, 1));
      // lengths that differ only below the truncated fraction tie
      triangle_queue.push_back(vertices(-20000, 0, 0, 0, 0, 0, 20000, 1, 0));
      triangle_queue.push_back(vertices(-20000, 1, 0, 0, 0, 0, 20000, 0, 0));
      // small negative coordinates
      triangle_queue.push_back(vertices(-1, -1, -1, 0, 0, 0, 1, 1, 1));

      @(posedge clock);
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // idling phases: none, sender gaps, receiver stalls, both
      for (int phase = 0; phase < 4; phase++) begin
         @(negedge clock);
         case (phase)
            0: begin
               send_idle_pct  = 0;
               recv_stall_pct = 0;
            end
            1: begin
               send_idle_pct  = 68;
               recv_stall_pct = 0;
            end
            2: begin
               send_idle_pct  = 0;
               recv_stall_pct = 68;
            end
            default: begin
               send_idle_pct  = 20;
               recv_stall_pct = 20;
            end
         endcase
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            kind = $urandom_range(99);
            for (int k = 0; k < 9; k++) begin
               pt[k] = $urandom_range(65535) - 32768;
            end
            if (kind < 35) begin
               // full range, every bit of every field toggles
            end else if (kind < 60) begin
               // tight triangle around vertex one, short sides and near ties
               for (int k = 3; k < 9; k++) begin
                  pt[k] = pt[k % 3] + $urandom_range(16) - 8;
               end
            end else if (kind < 75) begin
               // one vertex copied onto another
               a = $urandom_range(2);
               b = (a + 1 + $urandom_range(1)) % 3;
               for (int j = 0; j < 3; j++) begin
                  pt[b * 3 + j] = pt[a * 3 + j];
               end
            end else if (kind < 85) begin
               // coordinates from the corners of the range
               for (int k = 0; k < 9; k++) begin
                  pt[k] = corner[$urandom_range(4)];
               end
            end else begin
               // isosceles about vertex one, sides 1-2 and 3-1 equal
               for (int j = 0; j < 3; j++) begin
                  pt[j]   = $urandom_range(60000) - 30000;
                  offs[j] = $urandom_range(2000) - 1000;
               end
               for (int j = 0; j < 3; j++) begin
                  pt[3 + j] = pt[j] + offs[j];
                  pt[6 + j] = pt[j] - offs[(j + 1) % 3];
               end
            end
            triangle_queue.push_back(vertices(pt[0], pt[1], pt[2], pt[3], pt[4], pt[5],
                                              pt[6], pt[7], pt[8]));
         end
         while (triangle_queue.size() != 0) begin
            @(negedge clock);
         end
      end

      // everything handed over, now wait for the owed responses to come back
      while (req_valid || expected_sides.size() != 0) begin
         @(negedge clock);
      end
      // catch any stray response after the last one
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (error_count == 0) begin
         $display("[triangle_shortest_side_3d] OK");
      end else begin
         $display("[triangle_shortest_side_3d] ERROR");
      end
      $finish;
   end

endmodule
